// ----- rtl/emf_pkg.sv -----
`default_nettype none
package emf_pkg;

  // group size and derived widths
  localparam int SAMPLES  = 5;
  localparam int IDX_W    = $clog2(SAMPLES);
  localparam int RANK_W   = $clog2(SAMPLES + 1);
  localparam int MED_RANK = SAMPLES / 2;

  // field widths
  localparam int DUR_W  = 16;
  localparam int CM_W   = 10;
  localparam int FILL_W = 11;
  localparam int ST_W   = 3;
  localparam int CFG_W  = 10;
  localparam int CFG_IDX_W = 1;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  // signed difference of two config-range values, and p = diff * 100
  localparam int SDIFF_W = CFG_W + 1;
  localparam int P_W     = 18;
  localparam int TPROD_W = 17;
  localparam int THR_W   = 7;

  // fill arithmetic
  localparam int FA_W = 21;  // diff * 2000
  localparam int FB_W = 22;  // 2401 * span

  // shared serial divider: quotient is known to fit QUO_W bits
  localparam int DIVD_W = 25;
  localparam int DIVS_W = 15;
  localparam int QUO_W  = 11;
  localparam int QCNT_W = 4;

  localparam int CM_MUL     = 343;
  localparam int CM_DIV     = 20000;
  localparam int TIMEOUT_CM = 999;
  localparam int FILL_MAX   = 1200;
  localparam int FILL_NUM   = 2000;
  localparam int FILL_CLAMP = 2401;  // fill > max  <=>  diff*2000 >= 2401*span
  localparam int PCT        = 100;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL  = 1'd1;
  localparam logic [CFG_W-1:0] EMPTY_RST = 10'd100;
  localparam logic [CFG_W-1:0] FULL_RST  = 10'd5;

  // level codes
  localparam logic [ST_W-1:0] LVL_UNKNOWN  = 3'd0;
  localparam logic [ST_W-1:0] LVL_NORMAL   = 3'd1;
  localparam logic [ST_W-1:0] LVL_FILLING  = 3'd2;
  localparam logic [ST_W-1:0] LVL_NEAR     = 3'd3;
  localparam logic [ST_W-1:0] LVL_FULL     = 3'd4;
  localparam logic [ST_W-1:0] LVL_OVERFLOW = 3'd5;

  // status search: step 0 is the hold check, then the enter list
  localparam int STEP_W  = 3;
  localparam int ENTER_N = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_MED_GO,
    ST_MED,
    ST_PREP,
    ST_FILL_GO,
    ST_FDIV,
    ST_PUB
  } emf_state_t;

  function automatic logic has_hold(input logic [ST_W-1:0] st);
    has_hold = (st == LVL_FILLING) || (st == LVL_NEAR) ||
               (st == LVL_FULL) || (st == LVL_OVERFLOW);
  endfunction

  function automatic logic [THR_W-1:0] hold_thr(input logic [ST_W-1:0] st);
    case (st)
      LVL_OVERFLOW: hold_thr = 7'd98;
      LVL_FULL:     hold_thr = 7'd92;
      LVL_NEAR:     hold_thr = 7'd82;
      LVL_FILLING:  hold_thr = 7'd66;
      default:      hold_thr = 7'd0;
    endcase
  endfunction

  function automatic logic [THR_W-1:0] enter_thr(input logic [STEP_W-1:0] step);
    case (step)
      3'd1:    enter_thr = 7'd100;
      3'd2:    enter_thr = 7'd95;
      3'd3:    enter_thr = 7'd85;
      3'd4:    enter_thr = 7'd70;
      default: enter_thr = 7'd0;
    endcase
  endfunction

  function automatic logic [ST_W-1:0] enter_status(input logic [STEP_W-1:0] step);
    case (step)
      3'd1:    enter_status = LVL_OVERFLOW;
      3'd2:    enter_status = LVL_FULL;
      3'd3:    enter_status = LVL_NEAR;
      3'd4:    enter_status = LVL_FILLING;
      default: enter_status = LVL_NORMAL;
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- rtl/emf_div.sv -----
`default_nettype none
module emf_div import emf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [DIVS_W-1:0] divisor,
  output logic                   busy,
  output logic                   done,
  output logic [QUO_W-1:0]       quotient
);

  logic [DIVD_W-1:0] rem_r;
  logic [DIVD_W-1:0] dvs_r;
  logic [QUO_W-1:0]  quo_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              fits;

  // restoring division, one quotient bit per cycle, MSB first
  assign fits = rem_r >= dvs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= QCNT_W'(QUO_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dvs_r <= {divisor, {(QUO_W-1){1'b0}}};
      quo_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - dvs_r;
      end
      quo_r <= {quo_r[QUO_W-2:0], fits};
      dvs_r <= dvs_r >> 1;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ----- rtl/emf_med.sv -----
`default_nettype none
module emf_med import emf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire logic [CM_W-1:0]  wr_data,
  input  wire logic             start,
  output logic                  done,
  output logic [CM_W-1:0]       median,
  output logic [CM_W-1:0]       first
);

  logic [CM_W-1:0]   smp_r [SAMPLES];
  logic [IDX_W-1:0]  cand_r;
  logic              busy_r;
  logic              done_r;
  logic [CM_W-1:0]   med_r;
  logic [CM_W-1:0]   cval;
  logic [RANK_W-1:0] rank;
  logic              found;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      smp_r[wr_idx] <= wr_data;
    end
  end

  // stable rank of the candidate: smaller ones, plus equal ones placed ahead
  always_comb begin
    cval = smp_r[cand_r];
    rank = '0;
    for (int j = 0; j < SAMPLES; j++) begin
      if (smp_r[j] < cval) begin
        rank = rank + RANK_W'(1);
      end else if (smp_r[j] == cval && IDX_W'(j) < cand_r) begin
        rank = rank + RANK_W'(1);
      end
    end
    found = rank == RANK_W'(MED_RANK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cand_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cand_r <= '0;
      end else if (busy_r) begin
        if (found) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cand_r <= cand_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && found) begin
      med_r <= cval;
    end
  end

  assign done   = done_r;
  assign median = med_r;
  assign first  = smp_r[0];

endmodule
`default_nettype wire

// ----- rtl/emf_status.sv -----
`default_nettype none
module emf_status import emf_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic signed [SDIFF_W-1:0] diff,
  input  wire logic signed [SDIFF_W-1:0] span,
  output logic                           busy,
  output logic [ST_W-1:0]                status,
  output logic                           changed
);

  logic signed [P_W-1:0] p_r;
  logic [CFG_W-1:0]      span_r;
  logic [STEP_W-1:0]     step_r;
  logic                  busy_r;
  logic [ST_W-1:0]       cur_r;
  logic [ST_W-1:0]       status_r;
  logic                  changed_r;

  logic [THR_W-1:0]      thr;
  logic [TPROD_W-1:0]    tprod;
  logic                  pass;
  logic                  finish;
  logic [ST_W-1:0]       res;
  logic                  span_bad;

  assign span_bad = span[SDIFF_W-1] || (span == '0);

  always_comb begin
    thr    = (step_r == '0) ? hold_thr(cur_r) : enter_thr(step_r);
    tprod  = TPROD_W'(span_r) * TPROD_W'(thr);
    pass   = p_r >= $signed({1'b0, tprod});
    // hold check only counts when the last status has a hold level
    if (step_r == '0) begin
      pass = pass && has_hold(cur_r);
    end
    finish = pass || (step_r == STEP_W'(ENTER_N));
    if (!pass) begin
      res = LVL_NORMAL;
    end else if (step_r == '0) begin
      res = cur_r;
    end else begin
      res = enter_status(step_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      step_r    <= '0;
      cur_r     <= LVL_UNKNOWN;
      status_r  <= LVL_NORMAL;
      changed_r <= 1'b0;
    end else if (start) begin
      step_r <= '0;
      if (span_bad) begin
        status_r  <= LVL_NORMAL;
        changed_r <= (cur_r != LVL_UNKNOWN) && (cur_r != LVL_NORMAL);
        cur_r     <= LVL_NORMAL;
      end else begin
        busy_r <= 1'b1;
      end
    end else if (busy_r) begin
      if (finish) begin
        busy_r    <= 1'b0;
        status_r  <= res;
        changed_r <= (cur_r != LVL_UNKNOWN) && (res != cur_r);
        cur_r     <= res;
      end else begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p_r    <= P_W'(diff) * P_W'(PCT);
      span_r <= span[CFG_W-1:0];
    end
  end

  assign busy    = busy_r;
  assign status  = status_r;
  assign changed = changed_r;

endmodule
`default_nettype wire

// ----- rtl/echo_median_fill_level_classifier_top.sv -----
// Sequence: each item inside a group is converted to cm by an 11-step serial division; the
// closing item then raises out_tvalid after a 1 to 5 step median scan and an 11-step
// fill division, the fill division being skipped when the fill is zero or clamped.
// Flow: in_tready stays low until the shared divider has converted the item; the closing item
// holds the input until its result is loaded, plus any wait for out_tready.
// Reset: synchronous active-low; clears control, index, last status; empty 100, full 5 cm.
`default_nettype none
module echo_median_fill_level_classifier_top import emf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: [15:0] echo_duration_us
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // out_tdata: [9:0] first_distance_cm, [19:10] median_distance_cm,
  // [30:20] fill_tenths, [33:31] level_status, [34] status_changed, [39:35] zero
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  emf_state_t state_r, state_nxt;

  logic [CFG_W-1:0]          empty_r;
  logic [CFG_W-1:0]          full_r;
  logic [IDX_W-1:0]          idx_r;
  logic                      dur_zero_r;
  logic signed [SDIFF_W-1:0] span_r;
  logic signed [SDIFF_W-1:0] diff_r;
  logic [FA_W-1:0]           prod_a_r;
  logic [FB_W-1:0]           prod_b_r;
  logic [FILL_W-1:0]         fill_r;
  logic                      out_valid_r;
  logic [OUT_DATA_W-1:0]     out_data_r;

  logic                      accept;
  logic                      last_smp;
  logic                      fill_zero;
  logic                      fill_clamp;
  logic                      div_start;
  logic                      med_start;
  logic                      st_start;
  logic                      smp_we;
  logic                      out_load;
  logic [DIVD_W-1:0]         div_dividend;
  logic [DIVS_W-1:0]         div_divisor;
  logic                      div_busy;
  logic                      div_done;
  logic [QUO_W-1:0]          div_q;
  logic [CM_W-1:0]           cm_c;
  logic                      med_done;
  logic [CM_W-1:0]           med_val;
  logic [CM_W-1:0]           first_val;
  logic signed [SDIFF_W-1:0] diff_c;
  logic signed [SDIFF_W-1:0] span_c;
  logic                      st_busy;
  logic [ST_W-1:0]           st_val;
  logic                      st_changed;

  assign accept    = in_tvalid && in_tready;
  assign last_smp  = idx_r == IDX_W'(SAMPLES - 1);
  assign fill_zero = span_r[SDIFF_W-1] || (span_r == '0) ||
                     diff_r[SDIFF_W-1] || (diff_r == '0);
  assign fill_clamp = FB_W'(prod_a_r) >= prod_b_r;
  assign diff_c = $signed({1'b0, empty_r}) - $signed({1'b0, med_val});
  assign span_c = $signed({1'b0, empty_r}) - $signed({1'b0, full_r});

  // timeout and saturation of the converted distance
  assign cm_c = (dur_zero_r || div_q > QUO_W'(TIMEOUT_CM)) ? CM_W'(TIMEOUT_CM)
                                                           : div_q[CM_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_tvalid) state_nxt = ST_CONV;
      ST_CONV: begin
        if (div_done) state_nxt = last_smp ? ST_MED_GO : ST_IDLE;
      end
      ST_MED_GO:  state_nxt = ST_MED;
      ST_MED:     if (med_done) state_nxt = ST_PREP;
      ST_PREP:    state_nxt = ST_FILL_GO;
      ST_FILL_GO: state_nxt = (fill_zero || fill_clamp) ? ST_PUB : ST_FDIV;
      ST_FDIV:    if (div_done) state_nxt = ST_PUB;
      ST_PUB:     if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready    = 1'b0;
    div_start    = 1'b0;
    med_start    = 1'b0;
    st_start     = 1'b0;
    smp_we       = 1'b0;
    out_load     = 1'b0;
    div_dividend = DIVD_W'(in_tdata[DUR_W-1:0]) * DIVD_W'(CM_MUL);
    div_divisor  = DIVS_W'(CM_DIV);
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        div_start = in_tvalid;
      end
      ST_CONV:    smp_we = div_done;
      ST_MED_GO:  med_start = 1'b1;
      ST_PREP:    st_start = 1'b1;
      ST_FILL_GO: begin
        div_start    = !(fill_zero || fill_clamp);
        // round half up: (2000*diff + span) / (2*span)
        div_dividend = DIVD_W'(prod_a_r) + DIVD_W'(span_r[CFG_W-1:0]);
        div_divisor  = DIVS_W'({span_r[CFG_W-1:0], 1'b0});
      end
      ST_PUB:     out_load = !st_busy && (!out_valid_r || out_tready);
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      empty_r     <= EMPTY_RST;
      full_r      <= FULL_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (smp_we) begin
        idx_r <= last_smp ? '0 : idx_r + 1'b1;
      end
      if (cfg_valid) begin
        if (cfg_index == CFG_EMPTY) begin
          empty_r <= cfg_data;
        end else if (cfg_index == CFG_FULL) begin
          full_r <= cfg_data;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dur_zero_r <= in_tdata[DUR_W-1:0] == '0;
    end
    if (state_r == ST_PREP) begin
      span_r   <= span_c;
      diff_r   <= diff_c;
      prod_a_r <= FA_W'(diff_c[CFG_W-1:0]) * FA_W'(FILL_NUM);
      prod_b_r <= FB_W'(span_c[CFG_W-1:0]) * FB_W'(FILL_CLAMP);
    end
    if (state_r == ST_FILL_GO) begin
      fill_r <= fill_zero ? '0 : FILL_W'(FILL_MAX);
    end else if (state_r == ST_FDIV && div_done) begin
      fill_r <= div_q;
    end
    if (out_load) begin
      out_data_r <= OUT_DATA_W'({st_changed, st_val, fill_r, med_val, first_val});
    end
  end

  emf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  emf_med u_med (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (smp_we),
    .wr_idx  (idx_r),
    .wr_data (cm_c),
    .start   (med_start),
    .done    (med_done),
    .median  (med_val),
    .first   (first_val)
  );

  emf_status u_status (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (st_start),
    .diff    (diff_c),
    .span    (span_c),
    .busy    (st_busy),
    .status  (st_val),
    .changed (st_changed)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

`ifndef SYNTHESIS
  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_med_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    med_done |-> state_r == ST_MED)
    else $error("median done outside median wait");

  a_out_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[33:31] == LVL_NORMAL || out_data_r[33:31] == LVL_FILLING ||
                     out_data_r[33:31] == LVL_NEAR || out_data_r[33:31] == LVL_FULL ||
                     out_data_r[33:31] == LVL_OVERFLOW))
    else $error("bad level status in result");

  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r[30:20] <= FILL_W'(FILL_MAX))
    else $error("fill above clamp");
`endif

endmodule
`default_nettype wire
